@@ rtl/cacc_pkg.sv @@
// Package for the address-claim controller: widths, codes and result record.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps
package cacc_pkg;
    localparam int NameW = 64;
    localparam int DefTableDepth = 32;

    localparam logic [1:0] OP_FRAME  = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [2:0] RK_SEND   = 3'd0;
    localparam logic [2:0] RK_STATUS = 3'd1;
    localparam logic [2:0] RK_ENTRY  = 3'd2;
    localparam logic [2:0] RK_LOOKUP = 3'd3;
    localparam logic [2:0] RK_FULL   = 3'd4;

    localparam logic [2:0] ST_INIT    = 3'd0;
    localparam logic [2:0] ST_SEND    = 3'd1;
    localparam logic [2:0] ST_WAIT    = 3'd2;
    localparam logic [2:0] ST_BUILD   = 3'd3;
    localparam logic [2:0] ST_CLAIMED = 3'd4;
    localparam logic [2:0] ST_SELECT  = 3'd5;

    localparam logic [1:0] REG_NAME = 2'd0;
    localparam logic [1:0] REG_PREF = 2'd1;
    localparam logic [1:0] REG_WAIT = 2'd2;

    localparam logic [15:0] PGN_CLAIM = 16'hEEFF;
    localparam logic [15:0] PGN_REQ   = 16'hEAFF;
    localparam logic [7:0]  PF_CLAIM  = 8'hEE;
    localparam logic [7:0]  PF_REQ    = 8'hEA;
    localparam logic [23:0] REQ_CLAIM_PGN = 24'd60928;
    localparam logic [63:0] REQ_PAYLOAD = 64'hFFFF_FFFF_FF00_EE00;
    localparam logic [7:0]  ADDR_NULL = 8'hFF;
    localparam logic [7:0]  ADDR_BCAST = 8'hFF;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [15:0] tx_pgn;
        logic [2:0]  tx_priority;
        logic [7:0]  tx_source;
        logic [63:0] tx_payload;
        logic [2:0]  claim_state;
        logic [7:0]  claimed_address;
        logic [63:0] entry_name;
        logic [7:0]  entry_address;
        logic        found;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  rx_format;
        logic [7:0]  rx_specific;
        logic [7:0]  rx_source;
        logic [63:0] rx_payload;
    } item_t;

    // Next address after a lost contest: ((a - 127) rem 111) + 128, truncating.
    function automatic logic [7:0] next_address(input logic [7:0] a);
        logic [8:0] d;
        logic [7:0] m;
        if (a >= 8'd127)
        begin
            d = {1'b0, a} - 9'd127;
            m = (d >= 9'd111) ? 8'(d - 9'd111) : d[7:0];
            next_address = 8'(m + 8'd128);
        end
        else
        begin
            d = 9'd127 - {1'b0, a};
            m = (d >= 9'd111) ? 8'(d - 9'd111) : d[7:0];
            next_address = 8'(8'd128 - m);
        end
    endfunction
endpackage

@@ rtl/cacc_if.sv @@
// Valid/ready channel carrying one payload record.
// Depends on cacc_pkg for the default payload type.
`timescale 1ns / 1ps
interface cacc_if #(parameter type T = cacc_pkg::item_t);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/can_address_claim_controller.sv @@
// Top level of the address-claim controller: sequencer, claim state, output register.
// Depends on cacc_pkg, cacc_if and cacc_table.
`timescale 1ns / 1ps
// A new request is accepted only once the previous item is finished and the sequencer is
// idle again. The longest item is the tick that builds the table: it starts its table
// walk from the search state that follows acceptance and then emits up to three results.
// Claim frames and lookups start their walk on acceptance. Any request that touches
// the table walks every entry through the table's single read port, one entry per cycle.
// Each result then waits for the output register to be taken. The user must write
// configuration only while idle; the block itself does not enforce it.
module can_address_claim_controller import cacc_pkg::*; #(
    parameter int TableDepth = DefTableDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    cacc_if.sink        in_ch,
    cacc_if.source      out_ch
);
    localparam int IW = $clog2(TableDepth);

    typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_PUT, S_EMIT, S_DONE} seq_t;

    seq_t        seq_reg;
    item_t       item_reg;
    logic [63:0] own_name_reg;
    logic [7:0]  pref_reg;
    logic [7:0]  wait_ticks_reg;
    logic [2:0]  fsm_reg;
    logic [2:0]  prev_reg;
    logic [7:0]  cur_addr_reg;
    logic [7:0]  wait_cnt_reg;
    result_t     q_reg [3];
    logic [1:0]  qn_reg;
    logic [1:0]  qi_reg;
    logic [63:0] put_name_reg;
    logic [7:0]  put_addr_reg;
    logic        put_reg;
    logic        out_v_reg;
    result_t     out_reg;

    logic        t_start, t_done, t_hit, t_free;
    logic [IW-1:0] t_hit_idx, t_free_idx;
    logic [7:0]  t_hit_addr;
    logic        t_we;
    logic [IW-1:0] t_widx;
    logic [63:0] t_key;

    assign t_key = put_reg ? put_name_reg : item_reg.rx_payload;

    cacc_table #(.TableDepth(TableDepth)) u_table (
        .clk(clk), .rst_n(rst_n), .start(t_start), .key(t_key),
        .wr_en(t_we), .wr_idx(t_widx), .wr_name(put_name_reg), .wr_addr(put_addr_reg),
        .done(t_done), .hit(t_hit), .hit_idx(t_hit_idx), .hit_addr(t_hit_addr),
        .free_ok(t_free), .free_idx(t_free_idx)
    );

    assign in_ch.ready = (seq_reg == S_IDLE);
    assign out_ch.valid = out_v_reg;
    assign out_ch.data = out_reg;

    function automatic result_t frame_res(input logic req, input logic [7:0] sa,
                                          input logic [63:0] nm);
        result_t r;
        r = '0;
        r.result_kind = RK_SEND;
        r.tx_pgn = req ? PGN_REQ : PGN_CLAIM;
        r.tx_priority = req ? 3'd3 : 3'd6;
        r.tx_source = sa;
        r.tx_payload = req ? REQ_PAYLOAD : nm;
        return r;
    endfunction

    always_comb
    begin
        t_start = 1'b0;
        t_we = 1'b0;
        t_widx = t_hit ? t_hit_idx : t_free_idx;
        // Only a put writes the table; a lookup walk leaves it untouched.
        if (seq_reg == S_PUT && t_done && put_reg)
            t_we = t_hit ? (t_hit_addr != put_addr_reg) : t_free;
        if (in_ch.valid && in_ch.ready
            && ((in_ch.data.operation == OP_FRAME && in_ch.data.rx_format == PF_CLAIM)
                || in_ch.data.operation == OP_LOOKUP))
            t_start = 1'b1;
        if (seq_reg == S_SEARCH && put_reg)
            t_start = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        result_t r;
        logic [2:0] nf;
        logic [1:0] n;
        seq_t seq_next;
        logic out_v_next;
        logic put_next;
        logic [7:0] cur_addr_next;
        if (!rst_n)
        begin
            seq_reg <= S_IDLE;
            own_name_reg <= '0;
            pref_reg <= 8'd128;
            wait_ticks_reg <= 8'd3;
            fsm_reg <= ST_INIT;
            prev_reg <= ST_INIT;
            cur_addr_reg <= 8'd128;
            wait_cnt_reg <= '0;
            qn_reg <= '0;
            qi_reg <= '0;
            put_reg <= 1'b0;
            out_v_reg <= 1'b0;
            item_reg <= '0;
            put_name_reg <= '0;
            put_addr_reg <= '0;
            out_reg <= '0;
            for (int k = 0; k < 3; k++)
                q_reg[k] <= '0;
        end
        else
        begin
            r = '0;
            nf = fsm_reg;
            n = qn_reg;
            seq_next = seq_reg;
            out_v_next = out_v_reg;
            put_next = put_reg;
            cur_addr_next = cur_addr_reg;
            if (out_ch.valid && out_ch.ready)
                out_v_next = 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NAME: own_name_reg <= cfg_data;
                    REG_PREF:
                    begin
                        pref_reg <= cfg_data[7:0];
                        cur_addr_next = cfg_data[7:0];
                    end
                    REG_WAIT: wait_ticks_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            case (seq_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        item_reg <= in_ch.data;
                        qi_reg <= '0;
                        put_next = 1'b0;
                        n = 2'd0;
                        seq_next = S_DONE;
                        case (in_ch.data.operation)
                            OP_FRAME:
                            begin
                                if (in_ch.data.rx_format == PF_CLAIM)
                                begin
                                    if (in_ch.data.rx_source == cur_addr_reg)
                                        fsm_reg <= (own_name_reg < in_ch.data.rx_payload)
                                                   ? ST_SEND : ST_SELECT;
                                    put_name_reg <= in_ch.data.rx_payload;
                                    put_addr_reg <= in_ch.data.rx_source;
                                    put_next = 1'b1;
                                    seq_next = S_PUT;
                                end
                                else if (in_ch.data.rx_format == PF_REQ
                                    && (in_ch.data.rx_specific == cur_addr_reg
                                        || in_ch.data.rx_specific == ADDR_BCAST)
                                    && in_ch.data.rx_payload[23:0] == REQ_CLAIM_PGN
                                    && cur_addr_reg != ADDR_NULL)
                                    fsm_reg <= ST_SEND;
                            end
                            OP_TICK:
                            begin
                                case (fsm_reg)
                                    ST_INIT:
                                    begin
                                        wait_cnt_reg <= wait_ticks_reg;
                                        q_reg[n] <= frame_res(1'b0, cur_addr_reg, own_name_reg);
                                        n = n + 2'd1;
                                        nf = ST_WAIT;
                                    end
                                    ST_SEND:
                                    begin
                                        q_reg[n] <= frame_res(1'b0, cur_addr_reg, own_name_reg);
                                        n = n + 2'd1;
                                        nf = prev_reg;
                                    end
                                    ST_WAIT:
                                    begin
                                        if (wait_cnt_reg <= 8'd1)
                                        begin
                                            wait_cnt_reg <= '0;
                                            nf = ST_BUILD;
                                        end
                                        else
                                            wait_cnt_reg <= wait_cnt_reg - 8'd1;
                                    end
                                    ST_BUILD:
                                    begin
                                        q_reg[n] <= frame_res(1'b1, cur_addr_reg, own_name_reg);
                                        n = n + 2'd1;
                                        nf = ST_CLAIMED;
                                        put_name_reg <= own_name_reg;
                                        put_addr_reg <= cur_addr_reg;
                                        put_next = 1'b1;
                                        seq_next = S_SEARCH;
                                    end
                                    ST_SELECT:
                                    begin
                                        cur_addr_next = next_address(cur_addr_reg);
                                        wait_cnt_reg <= wait_ticks_reg;
                                        q_reg[n] <= frame_res(1'b0, next_address(cur_addr_reg),
                                                              own_name_reg);
                                        n = n + 2'd1;
                                        nf = ST_WAIT;
                                    end
                                    default: ;
                                endcase
                                fsm_reg <= nf;
                                prev_reg <= nf;
                                // Status for a build tick is queued after the table put.
                                if (nf != prev_reg && fsm_reg != ST_BUILD)
                                begin
                                    r.result_kind = RK_STATUS;
                                    r.claim_state = nf;
                                    q_reg[n] <= r;
                                    n = n + 2'd1;
                                end
                                if (fsm_reg != ST_BUILD)
                                    seq_next = (n != 2'd0) ? S_EMIT : S_DONE;
                            end
                            OP_LOOKUP: seq_next = S_PUT;
                            default: ;
                        endcase
                        qn_reg <= n;
                    end
                end
                S_SEARCH: seq_next = S_PUT;
                S_PUT:
                begin
                    if (t_done)
                    begin
                        if (item_reg.operation == OP_LOOKUP)
                        begin
                            r.result_kind = RK_LOOKUP;
                            r.entry_name = item_reg.rx_payload;
                            r.entry_address = t_hit ? t_hit_addr : 8'd0;
                            r.found = t_hit;
                            q_reg[n] <= r;
                            n = n + 2'd1;
                        end
                        else
                        begin
                            if (!t_hit && !t_free)
                            begin
                                r.result_kind = RK_FULL;
                                r.entry_name = put_name_reg;
                                q_reg[n] <= r;
                                n = n + 2'd1;
                            end
                            else if (!t_hit || t_hit_addr != put_addr_reg)
                            begin
                                r.result_kind = RK_ENTRY;
                                r.entry_name = put_name_reg;
                                r.entry_address = put_addr_reg;
                                q_reg[n] <= r;
                                n = n + 2'd1;
                            end
                            if (item_reg.operation == OP_TICK)
                            begin
                                // Build tick always moves to claimed, which is a change.
                                r = '0;
                                r.result_kind = RK_STATUS;
                                r.claim_state = ST_CLAIMED;
                                r.claimed_address = cur_addr_reg;
                                q_reg[n] <= r;
                                n = n + 2'd1;
                            end
                        end
                        qn_reg <= n;
                        seq_next = (n != 2'd0) ? S_EMIT : S_DONE;
                    end
                end
                S_EMIT:
                begin
                    if (!out_v_reg || out_ch.ready)
                    begin
                        r = q_reg[qi_reg];
                        r.last = (qi_reg + 2'd1 == qn_reg);
                        out_reg <= r;
                        out_v_next = 1'b1;
                        qi_reg <= qi_reg + 2'd1;
                        if (qi_reg + 2'd1 == qn_reg)
                            seq_next = S_DONE;
                    end
                end
                S_DONE: seq_next = S_IDLE;
                default: seq_next = S_IDLE;
            endcase
            seq_reg <= seq_next;
            out_v_reg <= out_v_next;
            put_reg <= put_next;
            cur_addr_reg <= cur_addr_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg != S_IDLE) |-> !in_ch.ready)
        else $error("input taken while an item is in progress");
    assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == S_EMIT) |-> (qn_reg != 2'd0) && (qi_reg < qn_reg))
        else $error("result queue index out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.data.result_kind == RK_STATUS
         && out_ch.data.claim_state != ST_CLAIMED) |-> (out_ch.data.claimed_address == 8'd0))
        else $error("claimed address reported outside claimed state");
endmodule

@@ rtl/cacc_table.sv @@
// Name-to-address table: one search walker compares one stored entry per cycle.
// Depends on cacc_pkg.
`timescale 1ns / 1ps
module cacc_table import cacc_pkg::*; #(
    parameter int TableDepth = DefTableDepth
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [63:0]                  key,
    input  logic                         wr_en,
    input  logic [$clog2(TableDepth)-1:0] wr_idx,
    input  logic [63:0]                  wr_name,
    input  logic [7:0]                   wr_addr,
    output logic                         done,
    output logic                         hit,
    output logic [$clog2(TableDepth)-1:0] hit_idx,
    output logic [7:0]                   hit_addr,
    output logic                         free_ok,
    output logic [$clog2(TableDepth)-1:0] free_idx
);
    localparam int IW = $clog2(TableDepth);
    localparam int CW = $clog2(TableDepth + 1);

    logic [63:0] names_mem [TableDepth];
    logic [7:0]  addr_mem [TableDepth];
    logic [TableDepth-1:0] valid_reg;
    logic        busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [63:0] rd_name_reg;
    logic [7:0]  rd_addr_reg;
    logic        rd_v_reg;
    logic        cmp_reg;
    logic [IW-1:0] cmp_idx_reg;

    // Read is registered; the compare works on the registered read of the previous counter value.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            names_mem[wr_idx] <= wr_name;
            addr_mem[wr_idx]  <= wr_addr;
        end
        rd_name_reg <= names_mem[cnt_reg[IW-1:0]];
        rd_addr_reg <= addr_mem[cnt_reg[IW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            cmp_reg <= 1'b0;
            cmp_idx_reg <= '0;
            rd_v_reg <= 1'b0;
            done <= 1'b0;
            hit <= 1'b0;
            hit_idx <= '0;
            hit_addr <= '0;
            free_ok <= 1'b0;
            free_idx <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (wr_en)
                valid_reg[wr_idx] <= 1'b1;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
                cmp_reg <= 1'b0;
                hit <= 1'b0;
                free_ok <= 1'b0;
            end
            else if (busy_reg)
            begin
                cmp_reg <= (cnt_reg < CW'(TableDepth));
                cmp_idx_reg <= cnt_reg[IW-1:0];
                rd_v_reg <= (cnt_reg < CW'(TableDepth)) && valid_reg[cnt_reg[IW-1:0]];
                if (cnt_reg < CW'(TableDepth))
                    cnt_reg <= CW'(cnt_reg + 1'b1);
                if (cmp_reg)
                begin
                    if (rd_v_reg && rd_name_reg == key && !hit)
                    begin
                        hit <= 1'b1;
                        hit_idx <= cmp_idx_reg;
                        hit_addr <= rd_addr_reg;
                    end
                    if (!rd_v_reg && !free_ok)
                    begin
                        free_ok <= 1'b1;
                        free_idx <= cmp_idx_reg;
                    end
                end
                else if (cnt_reg == CW'(TableDepth))
                begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
            end
        end
    end
endmodule

@@ test/cacc_claim_checker.sv @@
// Checker for the address-claim controller: tracks claim state and name table,
// predicts every result of each accepted request and compares it. Depends on cacc_pkg.
`timescale 1ns / 1ps
module cacc_claim_checker import cacc_pkg::*; #(
    parameter int TableDepth = DefTableDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        req_valid,
    input  logic        req_ready,
    input  item_t       req_data,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  result_t     rsp_data,
    output int          mismatches,
    output int          outstanding
);
    logic [63:0] node_name;
    logic [7:0]  pref_addr;
    logic [7:0]  wait_ticks;
    logic [2:0]  fsm;
    logic [2:0]  prev_fsm;
    logic [7:0]  cur_addr;
    logic [7:0]  wait_cnt;
    logic [63:0] tbl_name [TableDepth];
    logic [7:0]  tbl_addr [TableDepth];
    logic        tbl_valid [TableDepth];
    result_t     pending_results [$];

    assign outstanding = pending_results.size();

    function automatic int find_name(input logic [63:0] n);
        for (int i = 0; i < TableDepth; i++)
        begin
            if (tbl_valid[i] && tbl_name[i] == n)
                return i;
        end
        return -1;
    endfunction

    task automatic push_frame(input bit is_request);
        result_t r;
        r = '0;
        r.result_kind = RK_SEND;
        r.tx_pgn = is_request ? PGN_REQ : PGN_CLAIM;
        r.tx_priority = is_request ? 3'd3 : 3'd6;
        r.tx_source = cur_addr;
        r.tx_payload = is_request ? REQ_PAYLOAD : node_name;
        pending_results.push_back(r);
    endtask

    task automatic put_entry(input logic [63:0] n, input logic [7:0] a);
        result_t r;
        int idx;
        int slot;
        r = '0;
        idx = find_name(n);
        r.entry_name = n;
        if (idx >= 0)
        begin
            if (tbl_addr[idx] == a)
                return;
            tbl_addr[idx] = a;
        end
        else
        begin
            slot = -1;
            for (int i = TableDepth - 1; i >= 0; i--)
            begin
                if (!tbl_valid[i])
                    slot = i;
            end
            if (slot < 0)
            begin
                r.result_kind = RK_FULL;
                pending_results.push_back(r);
                return;
            end
            tbl_name[slot] = n;
            tbl_addr[slot] = a;
            tbl_valid[slot] = 1'b1;
        end
        r.result_kind = RK_ENTRY;
        r.entry_address = a;
        pending_results.push_back(r);
    endtask

    task automatic predict_request(input item_t it);
        int start;
        int idx;
        int d;
        result_t r;
        start = pending_results.size();
        r = '0;
        if (it.operation == OP_FRAME)
        begin
            if (it.rx_format == PF_CLAIM)
            begin
                if (it.rx_source == cur_addr)
                    fsm = (node_name < it.rx_payload) ? ST_SEND : ST_SELECT;
                put_entry(it.rx_payload, it.rx_source);
            end
            if (it.rx_format == PF_REQ
                && (it.rx_specific == cur_addr || it.rx_specific == ADDR_BCAST)
                && it.rx_payload[23:0] == REQ_CLAIM_PGN && cur_addr != ADDR_NULL)
                fsm = ST_SEND;
        end
        else if (it.operation == OP_TICK)
        begin
            case (fsm)
                ST_INIT:
                begin
                    wait_cnt = wait_ticks;
                    push_frame(1'b0);
                    fsm = ST_WAIT;
                end
                ST_SEND:
                begin
                    push_frame(1'b0);
                    fsm = prev_fsm;
                end
                ST_WAIT:
                begin
                    if (wait_cnt <= 8'd1)
                    begin
                        wait_cnt = '0;
                        fsm = ST_BUILD;
                    end
                    else
                        wait_cnt = wait_cnt - 8'd1;
                end
                ST_BUILD:
                begin
                    push_frame(1'b1);
                    fsm = ST_CLAIMED;
                    put_entry(node_name, cur_addr);
                end
                ST_SELECT:
                begin
                    // Remainder truncates toward zero, so low addresses land below 128.
                    d = (int'(cur_addr) - 127) % 111;
                    cur_addr = 8'(d + 128);
                    wait_cnt = wait_ticks;
                    push_frame(1'b0);
                    fsm = ST_WAIT;
                end
                default: ;
            endcase
            if (prev_fsm != fsm)
            begin
                r.result_kind = RK_STATUS;
                r.claim_state = fsm;
                r.claimed_address = (fsm == ST_CLAIMED) ? cur_addr : 8'd0;
                pending_results.push_back(r);
            end
            prev_fsm = fsm;
        end
        else if (it.operation == OP_LOOKUP)
        begin
            idx = find_name(it.rx_payload);
            r.result_kind = RK_LOOKUP;
            r.entry_name = it.rx_payload;
            if (idx >= 0)
            begin
                r.entry_address = tbl_addr[idx];
                r.found = 1'b1;
            end
            pending_results.push_back(r);
        end
        if (pending_results.size() > start)
            pending_results[pending_results.size() - 1].last = 1'b1;
    endtask

    task automatic check_field(input string field, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
            mismatches++;
        end
    endtask

    task automatic check_result(input result_t act);
        result_t e;
        if (pending_results.size() == 0)
        begin
            $error("result with nothing expected: kind %0d", act.result_kind);
            mismatches++;
            return;
        end
        e = pending_results.pop_front();
        check_field("result_kind", 64'(e.result_kind), 64'(act.result_kind));
        check_field("tx_pgn", 64'(e.tx_pgn), 64'(act.tx_pgn));
        check_field("tx_priority", 64'(e.tx_priority), 64'(act.tx_priority));
        check_field("tx_source", 64'(e.tx_source), 64'(act.tx_source));
        check_field("tx_payload", e.tx_payload, act.tx_payload);
        check_field("claim_state", 64'(e.claim_state), 64'(act.claim_state));
        check_field("claimed_address", 64'(e.claimed_address), 64'(act.claimed_address));
        check_field("entry_name", e.entry_name, act.entry_name);
        check_field("entry_address", 64'(e.entry_address), 64'(act.entry_address));
        check_field("found", 64'(e.found), 64'(act.found));
        check_field("last", 64'(e.last), 64'(act.last));
    endtask

    initial
    begin
        mismatches = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_name = '0;
            pref_addr = 8'd128;
            wait_ticks = 8'd3;
            fsm = ST_INIT;
            prev_fsm = ST_INIT;
            cur_addr = 8'd128;
            wait_cnt = '0;
            for (int i = 0; i < TableDepth; i++)
                tbl_valid[i] = 1'b0;
            pending_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_NAME)
                    node_name = cfg_data;
                else if (cfg_index == REG_PREF)
                begin
                    pref_addr = cfg_data[7:0];
                    cur_addr = cfg_data[7:0];
                end
                else if (cfg_index == REG_WAIT)
                    wait_ticks = cfg_data[7:0];
            end
            if (req_valid && req_ready)
                predict_request(req_data);
            if (rsp_valid && rsp_ready)
                check_result(rsp_data);
        end
    end
endmodule

@@ test/tb_top.sv @@
// Testbench top for the address-claim controller: clock, reset, configuration
// phases, directed and random requests. Depends on cacc_pkg, cacc_if, cacc_claim_checker.
`timescale 1ns / 1ps
module tb_top;
    import cacc_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int PoolSize = 40;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    int          mismatches;
    int          outstanding;
    bit          quiet;
    logic [63:0] name_pool [PoolSize];
    logic [63:0] cur_name;

    cacc_if #(.T(item_t))   req_ch ();
    cacc_if #(.T(result_t)) rsp_ch ();

    can_address_claim_controller DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (req_ch),
        .out_ch    (rsp_ch)
    );

    cacc_claim_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_valid   (req_ch.valid),
        .req_ready   (req_ch.ready),
        .req_data    (req_ch.data),
        .rsp_valid   (rsp_ch.valid),
        .rsp_ready   (rsp_ch.ready),
        .rsp_data    (rsp_ch.data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        rsp_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 9);
    end

    task automatic send(input item_t it);
        if (!quiet && $urandom_range(99) < 9)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= it;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic send_fields(input logic [1:0] op, input logic [7:0] pf,
                               input logic [7:0] ps, input logic [7:0] sa,
                               input logic [63:0] pl);
        item_t it;
        it.operation = op;
        it.rx_format = pf;
        it.rx_specific = ps;
        it.rx_source = sa;
        it.rx_payload = pl;
        send(it);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
    endtask

    task automatic configure(input logic [63:0] n, input logic [7:0] pref,
                             input logic [7:0] wt);
        write_reg(REG_NAME, n);
        write_reg(REG_PREF, 64'(pref));
        write_reg(REG_WAIT, 64'(wt));
        cfg_we <= 1'b0;
        cur_name = n;
        @(posedge clk);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        // A request that yields nothing may still be walking the table.
        repeat (100) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_request();
        int sel;
        logic [7:0] sa;
        logic [63:0] nm;
        sel = $urandom_range(99);
        sa = ($urandom_range(1) != 0) ? 8'($urandom_range(140, 120)) : 8'($urandom_range(255));
        case ($urandom_range(9))
            0: nm = cur_name;
            1: nm = cur_name + 64'd1;
            2: nm = cur_name - 64'd1;
            3, 4: nm = rand64();
            default: nm = name_pool[$urandom_range(PoolSize - 1)];
        endcase
        if (sel < 35)
            send_fields(OP_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), rand64());
        else if (sel < 62)
            send_fields(OP_FRAME, PF_CLAIM, 8'($urandom_range(255)), sa, nm);
        else if (sel < 74)
            send_fields(OP_FRAME, PF_REQ,
                        ($urandom_range(1) != 0) ? ADDR_BCAST : sa, sa,
                        ($urandom_range(3) != 0) ? {40'(rand64() >> 24), REQ_CLAIM_PGN}
                                                 : rand64());
        else if (sel < 80)
            send_fields(OP_FRAME, 8'($urandom_range(255)), 8'($urandom_range(255)),
                        sa, rand64());
        else if (sel < 95)
            send_fields(OP_LOOKUP, 8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), nm);
        else
            send_fields(OP_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), rand64());
    endtask

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
        begin
            quiet = (i >= count / 3 && i < count / 3 + 30);
            random_request();
        end
        quiet = 1'b0;
        drain();
    endtask

    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_NAME;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        quiet = 1'b0;
        cur_name = '0;
        for (int i = 0; i < PoolSize; i++)
            name_pool[i] = rand64();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(64'h8000_0000_0000_0000, 8'd128, 8'd1);
        // Claim sequence with the shortest wait, then lookups.
        send_fields(OP_TICK, 8'h00, 8'h00, 8'h00, 64'd0);
        send_fields(OP_TICK, 8'hFF, 8'hFF, 8'hFF, '1);
        send_fields(OP_TICK, 8'h00, 8'h00, 8'h00, 64'd0);
        send_fields(OP_TICK, 8'h00, 8'h00, 8'h00, 64'd0);
        send_fields(OP_LOOKUP, 8'h00, 8'h00, 8'h00, cur_name);
        send_fields(OP_LOOKUP, 8'hFF, 8'hFF, 8'hFF, '1);
        // A higher NAME on our address loses: we re-send the claim.
        send_fields(OP_FRAME, PF_CLAIM, 8'hFF, 8'd128, '1);
        send_fields(OP_TICK, 8'h00, 8'h00, 8'h00, 64'd0);
        // Requests for the claim PGN: to us, broadcast, and to someone else.
        send_fields(OP_FRAME, PF_REQ, 8'd128, 8'd5, {40'hFF_FFFF_FFFF, REQ_CLAIM_PGN});
        send_fields(OP_TICK, 8'h00, 8'h00, 8'h00, 64'd0);
        send_fields(OP_FRAME, PF_REQ, ADDR_BCAST, 8'd6, {40'd0, REQ_CLAIM_PGN});
        send_fields(OP_TICK, 8'h00, 8'h00, 8'h00, 64'd0);
        send_fields(OP_FRAME, PF_REQ, 8'd7, 8'd6, {40'd0, REQ_CLAIM_PGN});
        send_fields(OP_TICK, 8'h00, 8'h00, 8'h00, 64'd0);
        // An equal NAME on our address counts as a lost contest.
        send_fields(OP_FRAME, PF_CLAIM, 8'h00, 8'd128, cur_name);
        send_fields(OP_TICK, 8'h00, 8'h00, 8'h00, 64'd0);
        send_fields(OP_TICK, 8'h00, 8'h00, 8'h00, 64'd0);
        send_fields(OP_TICK, 8'h00, 8'h00, 8'h00, 64'd0);
        // A lower NAME on our new address also wins over us.
        send_fields(OP_FRAME, PF_CLAIM, 8'h00, 8'd129, 64'd0);
        send_fields(OP_FRAME, PF_CLAIM, 8'h00, 8'd0, 64'd1);
        send_fields(OP_FRAME, 8'h00, 8'h00, 8'hFF, '1);
        send_fields(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, '1);
        send_fields(OP_LOOKUP, 8'h00, 8'h00, 8'h00, 64'd1);
        drain();

        random_phase(90);
        configure('1, 8'd255, 8'd0);
        random_phase(90);
        configure(64'd0, 8'd0, 8'd255);
        random_phase(90);
        configure(rand64(), 8'($urandom_range(255)), 8'd3);
        random_phase(90);

        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
